[hdl/mcap_pkg.sv]
// ----------------------------------------------------------------------------
// Manchester audio packet stamper package
// Shared constants, codes and types of the packet stamper.
// ----------------------------------------------------------------------------
package mcap_pkg;

   localparam int SAMPLE_BITS_DEFAULT = 32;
   localparam int COUNT_BITS_DEFAULT = 16;
   localparam int MAX_SPB_DEFAULT = 254;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [6:0] SYNC_LEN = 7'd4;
   localparam logic [6:0] DATA_END = 7'd68;
   localparam logic [6:0] PACKET_BITS = 7'd76;

   localparam logic [7:0] CRC_POLY = 8'h2F;
   localparam logic [7:0] CRC_INIT = 8'hFF;
   localparam logic [7:0] CRC_XOROUT = 8'hFF;

   localparam logic [7:0] RESET_SPB = 8'd8;
   localparam logic [3:0] RESET_SYNC = 4'd10;
   localparam logic [31:0] RESET_POSITIVE = 32'h7FFF_FFFF;
   localparam logic [31:0] RESET_NEGATIVE = 32'h8000_0001;
   localparam logic [31:0] RESET_SILENCE = 32'h0000_0000;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SAMPLES_PER_BIT = 3'd0,
      CSR_SYNC_PATTERN    = 3'd1,
      CSR_POSITIVE_LEVEL  = 3'd2,
      CSR_NEGATIVE_LEVEL  = 3'd3,
      CSR_SILENCE_LEVEL   = 3'd4
   } csr_index_type;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_START = 1'b1;

   localparam logic STATUS_SAMPLE = 1'b0;
   localparam logic STATUS_SHORT = 1'b1;

   typedef struct packed {
      logic [7:0] spb;
      logic [3:0] sync;
   } ctrl_type;

   typedef struct packed {
      logic last;
      logic status;
   } flags_type;

   function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic data_bit);
      logic fb;
      fb = crc[7] ^ data_bit;
      return {crc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
   endfunction

endpackage

[hdl/mcap_csr.sv]
// ----------------------------------------------------------------------------
// Packet stamper control registers
// Holds the write-only settings and derives the effective bit length.
// ----------------------------------------------------------------------------
module mcap_csr #(
   parameter int SAMPLE_BITS = mcap_pkg::SAMPLE_BITS_DEFAULT,
   parameter int MAX_SAMPLES_PER_BIT = mcap_pkg::MAX_SPB_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [mcap_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [mcap_pkg::CSR_DATA_BITS-1:0]  csr_write_data,
   output mcap_pkg::ctrl_type                  ctrl,
   output logic [SAMPLE_BITS-1:0]              positive_level,
   output logic [SAMPLE_BITS-1:0]              negative_level,
   output logic [SAMPLE_BITS-1:0]              silence_level
);
   import mcap_pkg::*;

   localparam logic [7:0] SPB_MAX = 8'(MAX_SAMPLES_PER_BIT) & 8'hFE;

   logic [7:0]             spb_ff;
   logic [3:0]             sync_ff;
   logic [SAMPLE_BITS-1:0] positive_ff;
   logic [SAMPLE_BITS-1:0] negative_ff;
   logic [SAMPLE_BITS-1:0] silence_ff;
   logic [7:0]             spb_even;

   always_ff @(posedge clock) begin
      if (reset) begin
         spb_ff <= RESET_SPB;
         sync_ff <= RESET_SYNC;
         positive_ff <= RESET_POSITIVE[SAMPLE_BITS-1:0];
         negative_ff <= RESET_NEGATIVE[SAMPLE_BITS-1:0];
         silence_ff <= RESET_SILENCE[SAMPLE_BITS-1:0];
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_SAMPLES_PER_BIT: spb_ff <= csr_write_data[7:0];
            CSR_SYNC_PATTERN:    sync_ff <= csr_write_data[3:0];
            CSR_POSITIVE_LEVEL:  positive_ff <= csr_write_data[SAMPLE_BITS-1:0];
            CSR_NEGATIVE_LEVEL:  negative_ff <= csr_write_data[SAMPLE_BITS-1:0];
            CSR_SILENCE_LEVEL:   silence_ff <= csr_write_data[SAMPLE_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      spb_even = spb_ff & 8'hFE;
      ctrl.sync = sync_ff;
      if (spb_even < 8'd2) begin
         ctrl.spb = 8'd2;
      end else if (spb_even > SPB_MAX) begin
         ctrl.spb = SPB_MAX;
      end else begin
         ctrl.spb = spb_even;
      end
   end

   assign positive_level = positive_ff;
   assign negative_level = negative_ff;
   assign silence_level = silence_ff;

endmodule

[hdl/mcap_framer.sv]
// ----------------------------------------------------------------------------
// Packet stamper framer
// Holds the frame state and forms one sample word for each tick transfer within a frame.
// ----------------------------------------------------------------------------
module mcap_framer #(
   parameter int SAMPLE_BITS = mcap_pkg::SAMPLE_BITS_DEFAULT,
   parameter int COUNT_BITS = mcap_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_fire,
   input  logic                   operation,
   input  logic [63:0]            payload,
   input  logic [15:0]            frame_samples,
   input  mcap_pkg::ctrl_type     ctrl,
   input  logic [SAMPLE_BITS-1:0] positive_level,
   input  logic [SAMPLE_BITS-1:0] negative_level,
   input  logic [SAMPLE_BITS-1:0] silence_level,
   output logic                   res_valid,
   output logic [SAMPLE_BITS-1:0] res_sample,
   output mcap_pkg::flags_type    res_flags
);
   import mcap_pkg::*;

   logic [63:0]           shift_ff, shift_in;
   logic [7:0]            crc_ff, crc_in;
   logic [6:0]            bit_number_ff, bit_number_in;
   logic [7:0]            sample_in_bit_ff, sample_in_bit_in;
   logic [COUNT_BITS-1:0] samples_left_ff, samples_left_in;

   logic        busy;
   logic [16:0] need;
   logic        tx_bit;
   logic [2:0]  crc_k;
   logic [7:0]  crc_out;
   logic [7:0]  sample_next;
   logic        first_half;

   assign busy = samples_left_ff != '0;
   assign need = 17'(PACKET_BITS) * 17'(ctrl.spb);
   assign crc_k = 3'(bit_number_ff - DATA_END);
   assign crc_out = crc_ff ^ CRC_XOROUT;
   assign sample_next = sample_in_bit_ff + 8'd1;
   assign first_half = sample_in_bit_ff < (ctrl.spb >> 1);

   always_comb begin
      if (bit_number_ff < SYNC_LEN) begin
         tx_bit = ctrl.sync[2'd3 - bit_number_ff[1:0]];
      end else if (bit_number_ff < DATA_END) begin
         tx_bit = shift_ff[63];
      end else begin
         tx_bit = crc_out[3'd7 - crc_k];
      end
   end

   always_comb begin
      shift_in = shift_ff;
      crc_in = crc_ff;
      bit_number_in = bit_number_ff;
      sample_in_bit_in = sample_in_bit_ff;
      samples_left_in = samples_left_ff;
      res_valid = 1'b0;
      res_sample = '0;
      res_flags.last = 1'b0;
      res_flags.status = STATUS_SAMPLE;
      if (in_fire) begin
         if (operation == OP_START) begin
            if (frame_samples != 16'd0) begin
               if ({1'b0, frame_samples} < need) begin
                  res_valid = 1'b1;
                  res_flags.status = STATUS_SHORT;
               end else begin
                  shift_in = payload;
                  crc_in = CRC_INIT;
                  bit_number_in = 7'd0;
                  sample_in_bit_in = 8'd0;
                  samples_left_in = COUNT_BITS'(frame_samples);
               end
            end
         end else if (busy) begin
            res_valid = 1'b1;
            res_flags.last = samples_left_ff == COUNT_BITS'(1);
            samples_left_in = samples_left_ff - COUNT_BITS'(1);
            if (bit_number_ff < PACKET_BITS) begin
               res_sample = (tx_bit == first_half) ? positive_level : negative_level;
               sample_in_bit_in = sample_next;
               if (sample_next >= ctrl.spb) begin
                  sample_in_bit_in = 8'd0;
                  if (bit_number_ff >= SYNC_LEN && bit_number_ff < DATA_END) begin
                     crc_in = crc_step(crc_ff, tx_bit);
                     shift_in = {shift_ff[62:0], 1'b0};
                  end
                  bit_number_in = bit_number_ff + 7'd1;
               end
            end else begin
               res_sample = silence_level;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= '0;
         crc_ff <= CRC_INIT;
         bit_number_ff <= '0;
         sample_in_bit_ff <= '0;
         samples_left_ff <= '0;
      end else begin
         shift_ff <= shift_in;
         crc_ff <= crc_in;
         bit_number_ff <= bit_number_in;
         sample_in_bit_ff <= sample_in_bit_in;
         samples_left_ff <= samples_left_in;
      end
   end

endmodule

[hdl/mcap_out_reg.sv]
// ----------------------------------------------------------------------------
// Packet stamper result register
// Holds one result until the downstream side takes the transfer.
// ----------------------------------------------------------------------------
module mcap_out_reg #(
   parameter int SAMPLE_BITS = mcap_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  logic                   load_valid,
   input  logic [SAMPLE_BITS-1:0] load_sample,
   input  mcap_pkg::flags_type    load_flags,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic [SAMPLE_BITS-1:0] rsp_sample,
   output logic                   rsp_last,
   output logic                   rsp_status,
   output logic                   can_load
);
   import mcap_pkg::*;

   logic                   valid_ff;
   logic [SAMPLE_BITS-1:0] sample_ff;
   flags_type              flags_ff;

   assign can_load = !valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= load_valid;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sample_ff <= load_sample;
         flags_ff <= load_flags;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_sample = sample_ff;
   assign rsp_last = flags_ff.last;
   assign rsp_status = flags_ff.status;

endmodule

[hdl/manchester_audio_packet_stamper.sv]
// ----------------------------------------------------------------------------
// Manchester audio packet stamper
// Emits one audio channel's Manchester-coded packet with sync and CRC-8.
// ----------------------------------------------------------------------------
// A start transfer loads a 64-bit payload and a frame length; each tick
// transfer then yields one sample word: the sync nibble, the payload and its
// CRC-8 over samples_per_bit samples per bit, then silence to the frame end.
// The block takes one item per cycle while the output register can load;
// the transfer loads its result into the output register, and the input side
// stays ready while that register is empty or being emptied in the same cycle.
module manchester_audio_packet_stamper #(
   parameter int SAMPLE_BITS = mcap_pkg::SAMPLE_BITS_DEFAULT,
   parameter int COUNT_BITS = mcap_pkg::COUNT_BITS_DEFAULT,
   parameter int MAX_SAMPLES_PER_BIT = mcap_pkg::MAX_SPB_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_operation,
   input  logic [63:0]                         req_payload,
   input  logic [15:0]                         req_frame_samples,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [SAMPLE_BITS-1:0]              rsp_sample,
   output logic                                rsp_last,
   output logic                                rsp_status,
   input  logic                                csr_write_enable,
   input  logic [mcap_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [mcap_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);
   import mcap_pkg::*;

   ctrl_type               ctrl;
   logic [SAMPLE_BITS-1:0] positive_level;
   logic [SAMPLE_BITS-1:0] negative_level;
   logic [SAMPLE_BITS-1:0] silence_level;
   logic                   in_fire;
   logic                   res_valid;
   logic [SAMPLE_BITS-1:0] res_sample;
   flags_type              res_flags;
   logic                   can_load;

   assign req_ready = can_load;
   assign in_fire = req_valid && can_load;

   mcap_csr #(
      .SAMPLE_BITS         (SAMPLE_BITS),
      .MAX_SAMPLES_PER_BIT (MAX_SAMPLES_PER_BIT)
   ) u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .ctrl             (ctrl),
      .positive_level   (positive_level),
      .negative_level   (negative_level),
      .silence_level    (silence_level)
   );

   mcap_framer #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_framer (
      .clock          (clock),
      .reset          (reset),
      .in_fire        (in_fire),
      .operation      (req_operation),
      .payload        (req_payload),
      .frame_samples  (req_frame_samples),
      .ctrl           (ctrl),
      .positive_level (positive_level),
      .negative_level (negative_level),
      .silence_level  (silence_level),
      .res_valid      (res_valid),
      .res_sample     (res_sample),
      .res_flags      (res_flags)
   );

   mcap_out_reg #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_out_reg (
      .clock       (clock),
      .reset       (reset),
      .load        (in_fire),
      .load_valid  (res_valid),
      .load_sample (res_sample),
      .load_flags  (res_flags),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_sample  (rsp_sample),
      .rsp_last    (rsp_last),
      .rsp_status  (rsp_status),
      .can_load    (can_load)
   );

endmodule
